### hdl/fft_length_selector_unit_assert.svh
`ifndef FFT_LENGTH_SELECTOR_UNIT_ASSERT_SVH
`define FFT_LENGTH_SELECTOR_UNIT_ASSERT_SVH

// Clocked assertion with reset disable; clk and rst_n come from the scope.
`define FLS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication form of the same check.
`define FLS_ASSERT_IMP(lbl, ante, cons, msg) \
    `FLS_ASSERT(lbl, (ante) |-> (cons), msg)

// Next-cycle implication form.
`define FLS_ASSERT_NXT(lbl, ante, cons, msg) \
    `FLS_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

### hdl/fls_pkg.sv
package fls_pkg;

    localparam int ROM_DEPTH     = 240;
    localparam int TABLE_DEFAULT = 240;
    localparam int ROM_IW        = 8;
    localparam int LEN_W         = 20;
    localparam int COST_W        = 20;
    localparam int ENTRY_W       = LEN_W + COST_W;
    localparam int FIELD_W       = 21;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_FIRST_RD,
        ST_FIRST_EV,
        ST_BEST_RD,
        ST_BEST_EV,
        ST_DONE
    } fls_state_t;

    typedef struct packed {
        logic               operation;
        logic               real_mode;
        logic [FIELD_W-1:0] min_length;
        logic [FIELD_W-1:0] max_length;
    } fls_req_t;

    typedef struct packed {
        logic               valid;
        logic [FIELD_W-1:0] fft_length;
    } fls_res_t;

    localparam logic [LEN_W-1:0] ROM_LEN [ROM_DEPTH] = '{
        20'd1, 20'd2, 20'd3, 20'd4, 20'd5, 20'd6, 20'd7, 20'd8,
        20'd9, 20'd10, 20'd11, 20'd12, 20'd13, 20'd14, 20'd15, 20'd16,
        20'd18, 20'd20, 20'd21, 20'd22, 20'd24, 20'd26, 20'd28, 20'd30,
        20'd33, 20'd35, 20'd36, 20'd39, 20'd40, 20'd42, 20'd44, 20'd45,
        20'd48, 20'd52, 20'd55, 20'd56, 20'd60, 20'd63, 20'd65, 20'd66,
        20'd70, 20'd72, 20'd77, 20'd78, 20'd80, 20'd84, 20'd88, 20'd90,
        20'd91, 20'd99, 20'd104, 20'd105, 20'd110, 20'd112, 20'd117, 20'd120,
        20'd126, 20'd130, 20'd132, 20'd140, 20'd143, 20'd144, 20'd154, 20'd156,
        20'd165, 20'd168, 20'd176, 20'd180, 20'd182, 20'd195, 20'd198, 20'd208,
        20'd210, 20'd220, 20'd231, 20'd234, 20'd240, 20'd252, 20'd260, 20'd264,
        20'd273, 20'd280, 20'd286, 20'd308, 20'd312, 20'd315, 20'd330, 20'd336,
        20'd360, 20'd364, 20'd385, 20'd390, 20'd396, 20'd420, 20'd429, 20'd440,
        20'd455, 20'd462, 20'd468, 20'd495, 20'd504, 20'd520, 20'd528, 20'd546,
        20'd560, 20'd572, 20'd585, 20'd616, 20'd624, 20'd630, 20'd660, 20'd693,
        20'd715, 20'd720, 20'd728, 20'd770, 20'd780, 20'd792, 20'd819, 20'd840,
        20'd858, 20'd880, 20'd910, 20'd924, 20'd936, 20'd990, 20'd1001, 20'd1008,
        20'd1040, 20'd1092, 20'd1144, 20'd1155, 20'd1170, 20'd1232, 20'd1260, 20'd1287,
        20'd1320, 20'd1365, 20'd1386, 20'd1430, 20'd1456, 20'd1540, 20'd1560, 20'd1584,
        20'd1638, 20'd1680, 20'd1716, 20'd1820, 20'd1848, 20'd1872, 20'd1980, 20'd2002,
        20'd2145, 20'd2184, 20'd2288, 20'd2310, 20'd2340, 20'd2520, 20'd2574, 20'd2640,
        20'd2730, 20'd2772, 20'd2860, 20'd3003, 20'd3080, 20'd3120, 20'd3276, 20'd3432,
        20'd3465, 20'd3640, 20'd3696, 20'd3960, 20'd4004, 20'd4095, 20'd4290, 20'd4368,
        20'd4620, 20'd4680, 20'd5005, 20'd5040, 20'd5148, 20'd5460, 20'd5544, 20'd5720,
        20'd6006, 20'd6160, 20'd6435, 20'd6552, 20'd6864, 20'd6930, 20'd7280, 20'd7920,
        20'd8008, 20'd8190, 20'd8580, 20'd9009, 20'd9240, 20'd9360, 20'd10010, 20'd10296,
        20'd10920, 20'd11088, 20'd11440, 20'd12012, 20'd12870, 20'd13104, 20'd13860,
        20'd15015,
        20'd16016, 20'd16380, 20'd17160, 20'd18018, 20'd18480, 20'd20020, 20'd20592,
        20'd21840,
        20'd24024, 20'd25740, 20'd27720, 20'd30030, 20'd32760, 20'd34320, 20'd36036,
        20'd40040,
        20'd45045, 20'd48048, 20'd51480, 20'd55440, 20'd60060, 20'd65520, 20'd72072,
        20'd80080,
        20'd90090, 20'd102960, 20'd120120, 20'd144144, 20'd180180, 20'd240240,
        20'd360360, 20'd720720
    };

    localparam logic [COST_W-1:0] ROM_COST [ROM_DEPTH] = '{
        20'd31, 20'd30, 20'd75, 20'd41, 20'd39, 20'd53, 20'd65, 20'd67,
        20'd51, 20'd67, 20'd58, 20'd30, 20'd91, 20'd84, 20'd87, 20'd63,
        20'd73, 20'd61, 20'd68, 20'd86, 20'd71, 20'd112, 20'd82, 20'd90,
        20'd115, 20'd93, 20'd118, 20'd157, 20'd126, 20'd128, 20'd133, 20'd141,
        20'd156, 20'd180, 20'd166, 20'd153, 20'd126, 20'd181, 20'd209, 20'd187,
        20'd152, 20'd187, 20'd210, 20'd274, 20'd227, 20'd212, 20'd234, 20'd274,
        20'd281, 20'd267, 20'd305, 20'd297, 20'd331, 20'd287, 20'd359, 20'd318,
        20'd309, 20'd416, 20'd373, 20'd403, 20'd455, 20'd378, 20'd437, 20'd485,
        20'd517, 20'd431, 20'd501, 20'd525, 20'd554, 20'd644, 20'd592, 20'd658,
        20'd645, 20'd632, 20'd689, 20'd760, 20'd737, 20'd728, 20'd823, 20'd756,
        20'd866, 20'd796, 20'd939, 20'd872, 20'd1010, 20'd956, 20'd1059, 20'd985,
        20'd1063, 20'd1119, 20'd1242, 20'd1404, 20'd1211, 20'd1346, 20'd1531, 20'd1374,
        20'd1524, 20'd1481, 20'd1553, 20'd1631, 20'd1431, 20'd1721, 20'd1730, 20'd1916,
        20'd1718, 20'd1934, 20'd1976, 20'd1779, 20'd2146, 20'd2012, 20'd2278, 20'd2283,
        20'd2660, 20'd2309, 20'd2342, 20'd2639, 20'd2890, 20'd2488, 20'd2660, 20'd2681,
        20'd3311, 20'd2941, 20'd3268, 20'd3106, 20'd3106, 20'd3534, 20'd3690, 20'd3165,
        20'd3690, 20'd3937, 20'd3891, 20'd4115, 20'd4386, 20'd4167, 20'd4255, 20'd4878,
        20'd4673, 20'd5263, 20'd4831, 20'd5714, 20'd5236, 20'd5525, 20'd5780, 20'd5525,
        20'd6173, 20'd6173, 20'd6757, 20'd6944, 20'd6410, 20'd7042, 20'd7463, 20'd8000,
        20'd9009, 20'd8130, 20'd8929, 20'd9091, 20'd9434, 20'd9009, 20'd10526, 20'd10417,
        20'd11494, 20'd10204, 20'd12048, 20'd12658, 20'd11494, 20'd12821, 20'd12987,
        20'd14493,
        20'd13889, 20'd14493, 20'd14706, 20'd15625, 20'd16949, 20'd16949, 20'd18519,
        20'd18519,
        20'd19608, 20'd19231, 20'd22222, 20'd20408, 20'd23256, 20'd25000, 20'd22222,
        20'd25641,
        20'd27778, 20'd27027, 20'd29412, 20'd27778, 20'd32258, 20'd31250, 20'd33333,
        20'd35714,
        20'd35714, 20'd38462, 20'd43478, 20'd41667, 20'd41667, 20'd43478, 20'd47619,
        20'd47619,
        20'd52632, 20'd50000, 20'd55556, 20'd58824, 20'd62500, 20'd62500, 20'd66667,
        20'd76923,
        20'd76923, 20'd83333, 20'd90909, 20'd90909, 20'd90909, 20'd100000, 20'd100000,
        20'd111111,
        20'd125000, 20'd125000, 20'd125000, 20'd166667, 20'd166667, 20'd200000,
        20'd166667, 20'd200000,
        20'd250000, 20'd250000, 20'd250000, 20'd250000, 20'd333333, 20'd333333,
        20'd333333, 20'd333333,
        20'd500000, 20'd500000, 20'd500000, 20'd500000, 20'd1000000, 20'd1000000,
        20'd1000000, 20'd1000000
    };

    // Entry image: cost in the upper half, length in the lower half.
    function automatic logic [ENTRY_W-1:0] rom_entry(input logic [ROM_IW-1:0] idx);
        logic [ENTRY_W-1:0] e;
        e = '0;
        if (int'(idx) < ROM_DEPTH)
        begin
            e = {ROM_COST[idx], ROM_LEN[idx]};
        end
        return e;
    endfunction

endpackage

### hdl/fls_ram.sv
module fls_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 240
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one entry, read one entry with registered data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hdl/fls_search.sv
module fls_search import fls_pkg::*; #(
    parameter int TABLE_ENTRIES = TABLE_DEFAULT
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  fls_req_t req,
    output fls_res_t res,
    input  logic     res_take
);

    localparam int USED = (TABLE_ENTRIES > ROM_DEPTH) ? ROM_DEPTH : TABLE_ENTRIES;
    localparam int IW   = $clog2(USED);
    localparam int CW   = $clog2(USED + 1);
    localparam logic [CW-1:0] LAST = CW'(USED - 1);

    fls_state_t           state_reg, state_next;
    logic [CW-1:0]        cnt_reg;
    logic                 op_reg, real_reg;
    logic [FIELD_W-1:0]   lo_reg, hi_reg;
    logic [LEN_W-1:0]     best_len_reg;
    logic [COST_W-1:0]    best_cost_reg;

    logic                 ram_we;
    logic [IW-1:0]        ram_addr;
    logic [ENTRY_W-1:0]   ram_rdata;
    logic [LEN_W-1:0]     rd_len;
    logic [COST_W-1:0]    rd_cost;
    logic                 below_lo, within_hi, more_left;
    logic [FIELD_W:0]     lo_sum, hi_sum;

    fls_ram #(.WIDTH(ENTRY_W), .DEPTH(USED)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_addr),
        .wdata (rom_entry(ROM_IW'(cnt_reg))),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

    assign rd_len    = ram_rdata[LEN_W-1:0];
    assign rd_cost   = ram_rdata[ENTRY_W-1:LEN_W];
    assign ram_addr  = cnt_reg[IW-1:0];
    assign below_lo  = {1'b0, rd_len} < lo_reg;
    assign within_hi = {1'b0, rd_len} <= hi_reg;
    assign more_left = cnt_reg < LAST;
    assign lo_sum    = {1'b0, req.min_length} + (FIELD_W+1)'(1);
    assign hi_sum    = {1'b0, req.max_length} + (FIELD_W+1)'(1);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:     if (cnt_reg == LAST) state_next = ST_IDLE;
            ST_IDLE:     if (req_valid) state_next = ST_FIRST_RD;
            ST_FIRST_RD: state_next = ST_FIRST_EV;
            ST_FIRST_EV:
            begin
                priority if (more_left && below_lo) state_next = ST_FIRST_RD;
                else if (op_reg)                    state_next = ST_BEST_RD;
                else                                state_next = ST_DONE;
            end
            ST_BEST_RD:  state_next = more_left ? ST_BEST_EV : ST_DONE;
            ST_BEST_EV:  state_next = within_hi ? ST_BEST_RD : ST_DONE;
            ST_DONE:     if (res_take) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        ram_we           = (state_reg == ST_INIT);
        req_ready        = (state_reg == ST_IDLE);
        res.valid        = (state_reg == ST_DONE);
        res.fft_length   = real_reg ? {best_len_reg, 1'b0} : {1'b0, best_len_reg};
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_INIT:     cnt_reg <= (cnt_reg == LAST) ? '0 : cnt_reg + CW'(1);
                ST_IDLE:     cnt_reg <= '0;
                ST_FIRST_EV:
                begin
                    if ((more_left && below_lo) || op_reg)
                    begin
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                end
                ST_BEST_EV:  if (within_hi) cnt_reg <= cnt_reg + CW'(1);
                default:     cnt_reg <= cnt_reg;
            endcase
        end
    end

    // Request and best-so-far payload
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && req_valid)
        begin
            op_reg   <= req.operation;
            real_reg <= req.real_mode;
            lo_reg   <= req.real_mode ? lo_sum[FIELD_W:1] : req.min_length;
            hi_reg   <= req.real_mode ? hi_sum[FIELD_W:1] : req.max_length;
        end
        if (state_reg == ST_FIRST_EV && !(more_left && below_lo))
        begin
            best_len_reg  <= rd_len;
            best_cost_reg <= rd_cost;
        end
        if (state_reg == ST_BEST_EV && within_hi && rd_cost < best_cost_reg)
        begin
            best_len_reg  <= rd_len;
            best_cost_reg <= rd_cost;
        end
    end

endmodule

### hdl/fft_length_selector_unit.sv
// FFT length selector.
// Input channel s_*: one beat is one query. tuser carries operation (bit 0:
// 0 smallest length not below min, 1 cheapest length up to max) and
// real_mode (bit 1: halve bounds rounding up, double the result). tdata
// carries min_length [20:0] and max_length [41:21].
// Output channel m_*: one beat per query, fft_length in tdata [20:0].
// One query is in work at a time. The length/cost table sits in a
// synchronous RAM with a registered read; each table entry visited takes a
// read state, then a compare state. A query steps through the table to
// the first entry not below min, then in cheapest mode on through the
// later entries while they do not exceed max.
// After reset the RAM is loaded from the constant table, one entry a
// cycle, TABLE_ENTRIES entries (capped at 240); s_tready stays low meanwhile.
// The result waits in an output register; while m_tready is low it holds,
// and the sequencer holds the next result until the register frees.
module fft_length_selector_unit import fls_pkg::*; #(
    parameter int TABLE_ENTRIES = TABLE_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // min_length [20:0], max_length [41:21], zeros
    input  logic [1:0]  s_tuser,   // operation [0], real_mode [1]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // fft_length [20:0], zeros
);

    fls_req_t            req;
    fls_res_t            res;
    logic                res_take;
    logic                out_valid_reg;
    logic [FIELD_W-1:0]  out_len_reg;

    assign req.operation  = s_tuser[0];
    assign req.real_mode  = s_tuser[1];
    assign req.min_length = s_tdata[20:0];
    assign req.max_length = s_tdata[41:21];

    fls_search #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_search (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req       (req),
        .res       (res),
        .res_take  (res_take)
    );

    // Take a result when the output register is empty or draining
    assign res_take = res.valid && (!out_valid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_len_reg <= res.fft_length;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_len_reg};

endmodule

### hdl/fls_checker.sv
`include "fft_length_selector_unit_assert.svh"

module fls_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // Stalled beat stays
    `FLS_ASSERT_NXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid, "m_tvalid dropped")
    // Stalled beat keeps its data
    `FLS_ASSERT_NXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata), "m_tdata changed")
    // A length is never zero and padding stays clear
    `FLS_ASSERT_IMP(a_len_ok, m_tvalid, m_tdata[20:0] != 21'd0 && m_tdata[23:21] == 3'd0, "bad length")
    // One query at a time: ready drops after an accepted beat
    `FLS_ASSERT_NXT(a_one_query, s_tvalid && s_tready, !s_tready, "second query taken")

endmodule

bind fft_length_selector_unit fls_checker u_fls_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### verif/testbench.sv
module testbench;
    import fls_pkg::*;

    typedef struct {
        logic               operation;
        logic               real_mode;
        logic [FIELD_W-1:0] min_length;
        logic [FIELD_W-1:0] max_length;
    } query_t;

    int unsigned error_count = 0;

    // Print one mismatch line and count it
    task automatic report_mismatch(input string what, input logic [20:0] got,
                                   input logic [20:0] want);
        error_count++;
        $display("MISMATCH %s: got %0d expected %0d", what, got, want);
    endtask

    // Table of valid lengths and costs, kept locally for the predictor
    int unsigned len_tab [240] = '{
        1,2,3,4,5,6,7,8,9,10,11,12,13,14,15,16,18,20,21,22,24,26,28,30,
        33,35,36,39,40,42,44,45,48,52,55,56,60,63,65,66,70,72,77,78,80,84,88,90,
        91,99,104,105,110,112,117,120,126,130,132,140,143,144,154,156,
        165,168,176,180,182,195,198,208,210,220,231,234,240,252,260,264,
        273,280,286,308,312,315,330,336,360,364,385,390,396,420,429,440,
        455,462,468,495,504,520,528,546,560,572,585,616,624,630,660,693,
        715,720,728,770,780,792,819,840,858,880,910,924,936,990,1001,1008,
        1040,1092,1144,1155,1170,1232,1260,1287,1320,1365,1386,1430,1456,1540,1560,1584,
        1638,1680,1716,1820,1848,1872,1980,2002,2145,2184,2288,2310,2340,2520,2574,2640,
        2730,2772,2860,3003,3080,3120,3276,3432,3465,3640,3696,3960,4004,4095,4290,4368,
        4620,4680,5005,5040,5148,5460,5544,5720,6006,6160,6435,6552,6864,6930,7280,7920,
        8008,8190,8580,9009,9240,9360,10010,10296,10920,11088,11440,12012,12870,13104,
        13860,15015,16016,16380,17160,18018,18480,20020,20592,21840,
        24024,25740,27720,30030,32760,34320,36036,40040,
        45045,48048,51480,55440,60060,65520,72072,80080,
        90090,102960,120120,144144,180180,240240,360360,720720};
    int unsigned cost_tab [240] = '{
        31,30,75,41,39,53,65,67,51,67,58,30,91,84,87,63,73,61,68,86,71,112,82,90,
        115,93,118,157,126,128,133,141,156,180,166,153,126,181,209,187,
        152,187,210,274,227,212,234,274,281,267,305,297,331,287,359,318,
        309,416,373,403,455,378,437,485,517,431,501,525,554,644,592,658,
        645,632,689,760,737,728,823,756,866,796,939,872,1010,956,1059,985,
        1063,1119,1242,1404,1211,1346,1531,1374,1524,1481,1553,1631,1431,1721,1730,1916,
        1718,1934,1976,1779,2146,2012,2278,2283,2660,2309,2342,2639,2890,2488,2660,2681,
        3311,2941,3268,3106,3106,3534,3690,3165,3690,3937,3891,4115,4386,4167,4255,4878,
        4673,5263,4831,5714,5236,5525,5780,5525,6173,6173,6757,6944,6410,7042,7463,8000,
        9009,8130,8929,9091,9434,9009,10526,10417,11494,10204,12048,12658,11494,12821,
        12987,14493,13889,14493,14706,15625,16949,16949,18519,18519,
        19608,19231,22222,20408,23256,25000,22222,25641,
        27778,27027,29412,27778,32258,31250,33333,35714,
        35714,38462,43478,41667,41667,43478,47619,47619,
        52632,50000,55556,58824,62500,62500,66667,76923,
        76923,83333,90909,90909,90909,100000,100000,111111,
        125000,125000,125000,166667,166667,200000,166667,200000,
        250000,250000,250000,250000,333333,333333,333333,333333,
        500000,500000,500000,500000,1000000,1000000,1000000,1000000};

    class length_scoreboard;
        logic [20:0] pending_lengths [$];
        int unsigned checked = 0;
        int unsigned n_cheapest = 0;
        int unsigned n_real = 0;

        // Predict the chosen length and queue it
        function void note_query(query_t q);
            int unsigned lo, hi, k, best, j, len;
            lo = q.min_length;
            hi = q.max_length;
            if (q.real_mode)
            begin
                lo = (lo + 1) >> 1;
                hi = (hi + 1) >> 1;
                n_real++;
            end
            k = 0;
            while (k + 1 < 240 && len_tab[k] < lo) k++;
            if (q.operation)
            begin
                n_cheapest++;
                best = k;
                for (j = k + 1; j + 1 < 240 && len_tab[j] <= hi; j++)
                    if (cost_tab[j] < cost_tab[best]) best = j;
                k = best;
            end
            len = len_tab[k];
            if (q.real_mode) len = len << 1;
            pending_lengths.push_back(len[20:0]);
        endfunction

        // Compare one output beat with the oldest prediction
        task check_length(logic [23:0] data);
            logic [20:0] want;
            checked++;
            if (pending_lengths.size() == 0)
            begin
                error_count++;
                $display("MISMATCH unexpected beat: %0d", data[20:0]);
                return;
            end
            want = pending_lengths.pop_front();
            if (data[20:0] !== want) report_mismatch("fft_length", data[20:0], want);
            if (data[23:21] !== 3'b000) report_mismatch("pad", data[23:21], 0);
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    length_scoreboard sb = new();
    bit quiet_phase = 1'b0;
    int unsigned hold_off_cycles = 0;
    int unsigned sent = 0;

    fft_length_selector_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #1 clk = ~clk;

    // Drop the whole run after a generous bound
    initial
    begin
        #20000000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Receiver: random stalls plus one long hold-off
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready) sb.check_length(m_tdata);
        if (hold_off_cycles > 0)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= quiet_phase ? 1'b1 : ($urandom_range(99) >= 7);
    end

    // Offer one beat, with an optional idle gap, and hold until accepted
    task automatic send_query(query_t q);
        if (!quiet_phase)
            while ($urandom_range(99) < 7)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        s_tvalid <= 1'b1;
        s_tuser  <= {q.real_mode, q.operation};
        s_tdata  <= {6'b0, q.max_length, q.min_length};
        do @(posedge clk); while (!s_tready);
        sb.note_query(q);
        sent++;
    endtask

    task automatic send_fields(bit op, bit rl, int unsigned lo, int unsigned hi);
        query_t q;
        q.operation = op;
        q.real_mode = rl;
        q.min_length = lo[20:0];
        q.max_length = hi[20:0];
        send_query(q);
    endtask

    // Mostly bounds near table lengths, some fully random
    function automatic int unsigned pick_bound();
        int unsigned r;
        r = $urandom_range(9);
        if (r < 6) return len_tab[$urandom_range(239)] + $urandom_range(2) - 1;
        if (r < 8) return $urandom_range(1441442);
        return $urandom_range(2097151);
    endfunction

    initial
    begin
        int unsigned lo, hi, wait_cycles;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, both modes, saturation, tight bounds, ties
        send_fields(0, 0, 0, 0);
        send_fields(1, 0, 0, 0);
        send_fields(0, 0, 2097151, 2097151);
        send_fields(1, 0, 2097151, 2097151);
        send_fields(0, 1, 2097151, 0);
        send_fields(1, 1, 2097151, 2097151);
        send_fields(1, 1, 0, 2097151);
        send_fields(1, 0, 0, 2097151);
        send_fields(1, 0, 720720, 720720);
        send_fields(1, 0, 360360, 720720);
        send_fields(0, 0, 720721, 0);
        send_fields(0, 1, 1441439, 0);
        send_fields(0, 1, 1441441, 0);
        send_fields(1, 0, 1000, 10);
        send_fields(1, 0, 924, 936);
        send_fields(1, 0, 1, 12);
        send_fields(1, 1, 3, 23);
        send_fields(0, 0, 13, 0);
        send_fields(1, 0, 90090, 144144);
        send_fields(0, 1, 1, 1);
        send_fields(1, 1, 1048575, 1048576);
        send_fields(0, 0, 1398101, 699050);

        // Long receiver hold-off while the sender keeps offering
        hold_off_cycles = 3000;
        for (int i = 0; i < 8; i++)
            send_fields($urandom_range(1), $urandom_range(1), pick_bound(), pick_bound());

        // Random queries; one stretch without idling
        for (int i = 0; i < 1820; i++)
        begin
            quiet_phase = (i >= 600 && i < 900);
            lo = pick_bound();
            hi = ($urandom_range(3) == 0) ? pick_bound() : lo + $urandom_range(lo * 4 + 8);
            send_fields($urandom_range(1), $urandom_range(1), lo, hi);
        end
        quiet_phase = 1'b0;
        s_tvalid <= 1'b0;

        wait_cycles = 0;
        while (sb.pending_lengths.size() != 0 && wait_cycles < 100000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (600) @(posedge clk);

        $display("Covered %0d queries (%0d cheapest, %0d real), %0d beats checked.",
                 sent, sb.n_cheapest, sb.n_real, sb.checked);
        if (error_count == 0 && sb.pending_lengths.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

### filelist.f
+incdir+hdl
hdl/fls_pkg.sv
hdl/fls_ram.sv
hdl/fls_search.sv
hdl/fft_length_selector_unit.sv
hdl/fls_checker.sv
verif/testbench.sv
